/* rtl/text_content_classifier_assert.svh */
// assertion macros for the text content classifier
// expects clk and rst_n in the scope of each use
`ifndef TEXT_CONTENT_CLASSIFIER_ASSERT_SVH
`define TEXT_CONTENT_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define TCC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcc check failed");

// next-cycle implication
`define TCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcc check failed");

`endif

/* rtl/tcc_pkg.sv */
// shared types, character constants and the per-position judge function
// no dependencies
package tcc_pkg;

    localparam int WIN_DEPTH   = 6;
    localparam int LOOK        = WIN_DEPTH - 1;
    localparam int LINE_PERIOD = 22;

    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_B      = 8'h62;

    typedef enum logic [2:0] {
        KIND_BINARY   = 3'd0,
        KIND_ASM      = 3'd1,
        KIND_NROFF    = 3'd2,
        KIND_COMMANDS = 3'd3,
        KIND_YACC     = 3'd4,
        KIND_XMAIL    = 3'd5,
        KIND_C        = 3'd6,
        KIND_TEXT     = 3'd7
    } kind_t;

    typedef struct packed {
        logic       at_line_start;
        logic       saw_sharp_or_semi;
        logic       saw_brace;
        logic       xmail_flag;
        logic       early_valid;
        kind_t      early_kind;
        logic [7:0] prev_byte;
        logic       prev_valid;
        logic [4:0] line_phase;
    } tcc_scan_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       final_req;
    } tcc_item_t;

    localparam tcc_scan_t SCAN_RESET = '{
        at_line_start:     1'b1,
        saw_sharp_or_semi: 1'b0,
        saw_brace:         1'b0,
        xmail_flag:        1'b0,
        early_valid:       1'b0,
        early_kind:        KIND_BINARY,
        prev_byte:         8'd0,
        prev_valid:        1'b0,
        line_phase:        5'd0
    };

    function automatic logic tcc_is_binary(input logic [7:0] c);
        return (c < CH_BEL) || ((c > CH_CR) && (c < CH_SPACE)) || (c > CH_TILDE);
    endfunction

    // judge one window position; ahead holds the following bytes, ahead_ok marks real ones
    function automatic tcc_scan_t tcc_judge(
        input tcc_scan_t             s,
        input logic [7:0]            c,
        input logic [LOOK-1:0][7:0]  ahead,
        input logic [LOOK-1:0]       ahead_ok
    );
        tcc_scan_t r;
        logic      done;
        logic      globl;
        logic      pct_next;
        logic      last_phase;
        r          = s;
        done       = s.early_valid;
        globl      = (c == CH_DOT) && (&ahead_ok)
                     && (ahead[0] == CH_G) && (ahead[1] == CH_L) && (ahead[2] == CH_O)
                     && (ahead[3] == CH_B) && (ahead[4] == CH_L);
        pct_next   = ahead_ok[0] && ((ahead[0] == CH_PCT) || (ahead[0] == CH_LBRACE)
                     || (ahead[0] == CH_RBRACE));
        last_phase = (s.line_phase == 5'(LINE_PERIOD - 1));
        if (!done && globl)
        begin
            r.early_valid = 1'b1;
            r.early_kind  = KIND_ASM;
            done          = 1'b1;
        end
        if (!done && s.at_line_start)
        begin
            if (c == CH_DOT)
            begin
                r.early_valid = 1'b1;
                r.early_kind  = KIND_NROFF;
                done          = 1'b1;
            end
            else if (c == CH_COLON)
            begin
                r.early_valid = 1'b1;
                r.early_kind  = KIND_COMMANDS;
                done          = 1'b1;
            end
            else if (c == CH_HASH)
            begin
                r.saw_sharp_or_semi = 1'b1;
            end
            else if ((c == CH_PCT) && pct_next)
            begin
                r.early_valid = 1'b1;
                r.early_kind  = KIND_YACC;
                done          = 1'b1;
            end
        end
        if (!done)
        begin
            if ((c == CH_LBRACE) || (c == CH_RBRACE))
            begin
                r.saw_brace = 1'b1;
            end
            if (c == CH_NL)
            begin
                r.at_line_start = 1'b1;
                if (s.prev_valid && (s.prev_byte == CH_SEMI))
                begin
                    r.saw_sharp_or_semi = 1'b1;
                end
                if (last_phase)
                begin
                    if (s.prev_valid && ((s.prev_byte == CH_SPACE) || (s.prev_byte == CH_BANG)))
                    begin
                        r.xmail_flag = 1'b1;
                    end
                end
                else
                begin
                    r.xmail_flag = 1'b0;
                end
            end
            else
            begin
                r.at_line_start = 1'b0;
            end
            r.prev_byte  = c;
            r.prev_valid = 1'b1;
            r.line_phase = last_phase ? 5'd0 : 5'(s.line_phase + 5'd1);
        end
        return r;
    endfunction

endpackage

/* rtl/tcc_byte_if.sv */
// input channel: one file byte per transfer with an end-of-file mark
// no dependencies
interface tcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_req;

    modport source (output valid, output data_byte, output final_req, input ready);
    modport sink   (input valid, input data_byte, input final_req, output ready);
endinterface

/* rtl/tcc_kind_if.sv */
// output channel: one class code per transfer
// no dependencies
interface tcc_kind_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;

    modport source (output valid, output kind, input ready);
    modport sink   (input valid, input kind, output ready);
endinterface

/* rtl/tcc_in_stage.sv */
// input register stage between the byte channel and the classifier core
// depends on tcc_pkg and tcc_byte_if
module tcc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    tcc_byte_if.sink            byte_in,
    input  logic                take,
    output tcc_pkg::tcc_item_t  item
);
    import tcc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       final_reg;
    logic       load;

    assign byte_in.ready = !valid_reg || take;
    assign load          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= byte_in.data_byte;
            final_reg <= byte_in.final_req;
        end
    end

    assign item = '{valid: valid_reg, data_byte: data_reg, final_req: final_reg};
endmodule

/* rtl/tcc_core.sv */
// classifier state, lookahead window, end-of-file drain and result register
// depends on tcc_pkg, tcc_kind_if and text_content_classifier_assert.svh
`include "text_content_classifier_assert.svh"
module tcc_core #(
    parameter int MAX_BYTES = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcc_pkg::tcc_item_t  item,
    output logic                take,
    tcc_kind_if.source          kind_out
);
    import tcc_pkg::*;

    localparam int CW = $clog2(MAX_BYTES + 1);

    tcc_scan_t                   scan_reg;
    tcc_scan_t                   scan_next;
    logic                        binary_reg;
    logic                        binary_next;
    logic [LOOK-1:0][7:0]        win_reg;
    logic [LOOK-1:0][7:0]        win_next;
    logic [2:0]                  fill_reg;
    logic [2:0]                  fill_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    kind_t                       kind_reg;
    kind_t                       kind_next;

    logic                        fire;
    logic                        counting;
    logic [2:0]                  n;
    logic [WIN_DEPTH-1:0][7:0]   ext;
    logic [WIN_DEPTH-1:0]        do_judge;
    logic [WIN_DEPTH-1:0][LOOK-1:0][7:0] ahead;
    logic [WIN_DEPTH-1:0][LOOK-1:0]      ahead_ok;
    tcc_scan_t                   chain [WIN_DEPTH+1];

    assign fire     = item.valid && (!item.final_req || !out_valid_reg || kind_out.ready);
    assign take     = fire;
    assign counting = (count_reg < CW'(MAX_BYTES));
    assign n        = 3'(fill_reg + {2'd0, counting});

    // window view with the new byte appended
    always_comb
    begin
        for (int k = 0; k < LOOK; k++)
        begin
            ext[k] = win_reg[k];
        end
        ext[LOOK] = 8'd0;
        if (counting)
        begin
            ext[fill_reg] = item.data_byte;
        end
    end

    // lookahead per position, bytes past the end never match
    always_comb
    begin
        for (int j = 0; j < WIN_DEPTH; j++)
        begin
            do_judge[j] = (j < int'(n))
                          && (item.final_req || ((j == 0) && (int'(n) == WIN_DEPTH)));
            for (int k = 0; k < LOOK; k++)
            begin
                ahead[j][k]    = (j + 1 + k < WIN_DEPTH) ? ext[(j + 1 + k) % WIN_DEPTH] : 8'd0;
                ahead_ok[j][k] = (j + 1 + k) < int'(n);
            end
        end
    end

    always_comb
    begin
        chain[0] = scan_reg;
        for (int j = 0; j < WIN_DEPTH; j++)
        begin
            chain[j+1] = do_judge[j] ? tcc_judge(chain[j], ext[j], ahead[j], ahead_ok[j])
                                     : chain[j];
        end
    end

    assign binary_next = binary_reg || (counting && tcc_is_binary(item.data_byte));

    always_comb
    begin
        if (binary_next)
        begin
            kind_next = KIND_BINARY;
        end
        else if (chain[WIN_DEPTH].early_valid)
        begin
            kind_next = chain[WIN_DEPTH].early_kind;
        end
        else if (chain[WIN_DEPTH].xmail_flag)
        begin
            kind_next = KIND_XMAIL;
        end
        else if (chain[WIN_DEPTH].saw_sharp_or_semi && chain[WIN_DEPTH].saw_brace)
        begin
            kind_next = KIND_C;
        end
        else
        begin
            kind_next = KIND_TEXT;
        end
    end

    always_comb
    begin
        scan_next  = scan_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        win_next   = win_reg;
        if (fire)
        begin
            if (item.final_req)
            begin
                scan_next  = SCAN_RESET;
                fill_next  = 3'd0;
                count_next = '0;
            end
            else
            begin
                scan_next  = chain[WIN_DEPTH];
                count_next = CW'(count_reg + {{(CW-1){1'b0}}, counting});
                for (int k = 0; k < LOOK; k++)
                begin
                    win_next[k] = (int'(n) == WIN_DEPTH) ? ext[k+1] : ext[k];
                end
                fill_next = (int'(n) == WIN_DEPTH) ? 3'(LOOK) : n;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && item.final_req)
        begin
            out_valid_next = 1'b1;
        end
        else if (kind_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= SCAN_RESET;
            binary_reg    <= 1'b0;
            fill_reg      <= 3'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_reg      <= scan_next;
            binary_reg    <= fire ? (binary_next && !item.final_req) : binary_reg;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (fire && item.final_req)
        begin
            kind_reg <= kind_next;
        end
    end

    assign kind_out.valid = out_valid_reg;
    assign kind_out.kind  = kind_reg;

    `TCC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= 3'(LOOK))
    `TCC_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(MAX_BYTES))
    `TCC_ASSERT_IMPL(a_phase_bound, 1'b1, scan_reg.line_phase <= 5'(LINE_PERIOD - 1))
    `TCC_ASSERT_NEXT(a_final_clears, fire && item.final_req,
        (fill_reg == 3'd0) && (count_reg == '0) && !binary_reg && scan_reg.at_line_start)
    `TCC_ASSERT_IMPL(a_result_cause, $rose(out_valid_reg), $past(fire && item.final_req))
endmodule

/* rtl/text_content_classifier.sv */
// result: the final byte passes the input register stage, then the class code is registered in the result register
// throughput: one byte per cycle; a final byte waits only while an earlier code is untaken
// each byte is judged against a five-byte lookahead window, drained at end of file
// reset: asynchronous, active low; empties the window, clears flags and byte count, no result pending
// state returns to reset values after each final byte
module text_content_classifier #(
    parameter int MAX_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    tcc_byte_if.sink    byte_in,
    tcc_kind_if.source  kind_out
);
    import tcc_pkg::*;

    tcc_item_t item;
    logic      take;

    tcc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .take    (take),
        .item    (item)
    );

    tcc_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .take     (take),
        .kind_out (kind_out)
    );
endmodule

/* verif/tb_text_content_classifier.sv */
// testbench for text_content_classifier: a directed table of small files, then random files
// built from character pieces, raw bytes or mail-like lines, checked against an in-bench scan of the same rules
// depends on tcc_pkg, tcc_byte_if, tcc_kind_if and the rtl top level
module tb_text_content_classifier;
    import tcc_pkg::*;

    localparam int MAX_BYTES    = 512;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [7:0] b;
        bit         fin;
        bit         typed;
        kind_t      want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tcc_byte_if byte_ch();
    tcc_kind_if kind_ch();

    text_content_classifier #(
        .MAX_BYTES(MAX_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_ch),
        .kind_out (kind_ch)
    );

    always #6 clk = ~clk;

    // scan state of the predicted classifier
    logic [7:0] w_bytes [WIN_DEPTH];
    int         w_fill;
    bit         p_line_start;
    bit         p_sharp_semi;
    bit         p_brace;
    bit         p_xmail;
    bit         p_binary;
    bit         p_early_ok;
    kind_t      p_early_kind;
    int         p_count;
    int         p_phase;
    logic [7:0] p_prev;
    bit         p_prev_ok;

    kind_t      pending_kinds[$];
    dir_row_t   dir_rows[$];
    logic [7:0] file_bytes[$];
    int         errors = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;

    task automatic clear_scan();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            w_bytes[i] = 8'd0;
        end
        w_fill       = 0;
        p_line_start = 1'b1;
        p_sharp_semi = 1'b0;
        p_brace      = 1'b0;
        p_xmail      = 1'b0;
        p_binary     = 1'b0;
        p_early_ok   = 1'b0;
        p_early_kind = KIND_BINARY;
        p_count      = 0;
        p_phase      = 0;
        p_prev       = 8'd0;
        p_prev_ok    = 1'b0;
    endtask

    // lookahead compare; positions past the end never match
    function automatic bit ahead_is(input int k, input logic [7:0] ch);
        return (k < w_fill) && (w_bytes[k] == ch);
    endfunction

    // judge the window head against its lookahead, then shift it out
    task automatic judge_and_drop();
        logic [7:0] c;
        bit         decided;
        if (w_fill == 0)
        begin
            return;
        end
        c       = w_bytes[0];
        decided = p_early_ok;
        if (!decided && (c == CH_DOT) && ahead_is(1, CH_G) && ahead_is(2, CH_L)
            && ahead_is(3, CH_O) && ahead_is(4, CH_B) && ahead_is(5, CH_L))
        begin
            p_early_ok   = 1'b1;
            p_early_kind = KIND_ASM;
            decided      = 1'b1;
        end
        if (!decided && p_line_start)
        begin
            if (c == CH_DOT)
            begin
                p_early_ok   = 1'b1;
                p_early_kind = KIND_NROFF;
                decided      = 1'b1;
            end
            else if (c == CH_COLON)
            begin
                p_early_ok   = 1'b1;
                p_early_kind = KIND_COMMANDS;
                decided      = 1'b1;
            end
            else if (c == CH_HASH)
            begin
                p_sharp_semi = 1'b1;
            end
            else if ((c == CH_PCT) && (ahead_is(1, CH_PCT) || ahead_is(1, CH_LBRACE)
                     || ahead_is(1, CH_RBRACE)))
            begin
                p_early_ok   = 1'b1;
                p_early_kind = KIND_YACC;
                decided      = 1'b1;
            end
        end
        if (!decided)
        begin
            if ((c == CH_LBRACE) || (c == CH_RBRACE))
            begin
                p_brace = 1'b1;
            end
            if (c == CH_NL)
            begin
                p_line_start = 1'b1;
                if (p_prev_ok && (p_prev == CH_SEMI))
                begin
                    p_sharp_semi = 1'b1;
                end
                if (p_phase == LINE_PERIOD - 1)
                begin
                    if (p_prev_ok && ((p_prev == CH_SPACE) || (p_prev == CH_BANG)))
                    begin
                        p_xmail = 1'b1;
                    end
                end
                else
                begin
                    p_xmail = 1'b0;
                end
            end
            else
            begin
                p_line_start = 1'b0;
            end
            p_prev    = c;
            p_prev_ok = 1'b1;
            p_phase   = (p_phase + 1) % LINE_PERIOD;
        end
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            w_bytes[i] = w_bytes[i + 1];
        end
        w_bytes[WIN_DEPTH - 1] = 8'd0;
        w_fill--;
    endtask

    task automatic scan_byte(input logic [7:0] b, input bit fin, output bit has, output kind_t k);
        has = 1'b0;
        k   = KIND_TEXT;
        if (p_count < MAX_BYTES)
        begin
            p_count++;
            if ((b < CH_BEL) || ((b > CH_CR) && (b < CH_SPACE)) || (b > CH_TILDE))
            begin
                p_binary = 1'b1;
            end
            if (w_fill < WIN_DEPTH)
            begin
                w_bytes[w_fill] = b;
                w_fill++;
            end
            if (w_fill == WIN_DEPTH)
            begin
                judge_and_drop();
            end
        end
        if (fin)
        begin
            while (w_fill > 0)
            begin
                judge_and_drop();
            end
            if (p_binary)
                k = KIND_BINARY;
            else if (p_early_ok)
                k = p_early_kind;
            else if (p_xmail)
                k = KIND_XMAIL;
            else if (p_sharp_semi && p_brace)
                k = KIND_C;
            else
                k = KIND_TEXT;
            has = 1'b1;
            clear_scan();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit fin, input bit typed, input kind_t want);
        int    gap;
        bit    has;
        kind_t k;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.final_req <= fin;
        do @(posedge clk); while (!byte_ch.ready);
        scan_byte(b, fin, has, k);
        if (has)
        begin
            pending_kinds.push_back(typed ? want : k);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input bit fin, input bit typed, input kind_t want);
        dir_row_t r;
        r.b     = b;
        r.fin   = fin;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    function automatic logic [7:0] letter();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // one character or a short token that drives a decision
    task automatic add_piece(input bit allow_bin);
        int pick;
        pick = $urandom_range(0, 27);
        case (pick)
            0, 1: file_bytes.push_back(CH_NL);
            2:    file_bytes.push_back(CH_DOT);
            3:    file_bytes.push_back(CH_COLON);
            4:    file_bytes.push_back(CH_PCT);
            5:    file_bytes.push_back(CH_LBRACE);
            6:    file_bytes.push_back(CH_RBRACE);
            7:    file_bytes.push_back(CH_HASH);
            8:    file_bytes.push_back(CH_SEMI);
            9:    file_bytes.push_back(CH_SPACE);
            10:   file_bytes.push_back(CH_BANG);
            11:   file_bytes.push_back(CH_G);
            12:   file_bytes.push_back(CH_L);
            13:   file_bytes.push_back(CH_O);
            14:   file_bytes.push_back(CH_B);
            15:   file_bytes.push_back(8'($urandom_range(CH_BEL, CH_CR)));
            16:   file_bytes.push_back(allow_bin ? 8'($urandom_range(0, 255)) : letter());
            17:
            begin
                file_bytes.push_back(CH_DOT);
                file_bytes.push_back(CH_G);
                file_bytes.push_back(CH_L);
                file_bytes.push_back(CH_O);
                file_bytes.push_back(CH_B);
                file_bytes.push_back(CH_L);
            end
            18:
            begin
                file_bytes.push_back(CH_NL);
                file_bytes.push_back(CH_PCT);
                case ($urandom_range(0, 2))
                    0:       file_bytes.push_back(CH_PCT);
                    1:       file_bytes.push_back(CH_LBRACE);
                    default: file_bytes.push_back(CH_RBRACE);
                endcase
            end
            19:
            begin
                file_bytes.push_back(CH_NL);
                file_bytes.push_back(CH_HASH);
            end
            20:
            begin
                file_bytes.push_back(CH_SEMI);
                file_bytes.push_back(CH_NL);
            end
            default: file_bytes.push_back(letter());
        endcase
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, each transfer checked against the oldest prediction
    initial
    begin
        int    stall;
        kind_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                @(negedge clk);
                kind_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            kind_ch.ready <= 1'b1;
            do @(posedge clk); while (!kind_ch.valid);
            if (pending_kinds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected class code %0d", kind_ch.kind);
            end
            else
            begin
                want = pending_kinds.pop_front();
                if (kind_ch.kind !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("class code mismatch: expected %0d got %0d", want, kind_ch.kind);
                end
            end
        end
    end

    initial
    begin
        int rand_sent;
        int file_no;
        int len;
        int lines;
        bit brk;
        bit allow_bin;
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'd0;
        byte_ch.final_req <= 1'b0;
        kind_ch.ready     <= 1'b0;
        clear_scan();
        rand_sent = 0;
        file_no   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed files, one byte per row
        add_row(8'h00, 1'b1, 1'b1, KIND_BINARY);
        add_row(8'hFF, 1'b1, 1'b1, KIND_BINARY);
        add_row(8'h7F, 1'b1, 1'b1, KIND_BINARY);
        add_row(8'h0E, 1'b1, 1'b1, KIND_BINARY);
        add_row(CH_BEL, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_CR, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_SPACE, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_TILDE, 1'b1, 1'b1, KIND_TEXT);
        add_row(CH_DOT, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_G, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_L, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_O, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_B, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_L, 1'b1, 1'b1, KIND_ASM);
        add_row(CH_COLON, 1'b1, 1'b1, KIND_COMMANDS);
        add_row(CH_PCT, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_PCT, 1'b1, 1'b1, KIND_YACC);
        add_row(CH_PCT, 1'b1, 1'b1, KIND_TEXT);
        add_row(CH_NL, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_DOT, 1'b1, 1'b1, KIND_NROFF);
        add_row(CH_HASH, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_LBRACE, 1'b1, 1'b0, KIND_TEXT);
        add_row(CH_DOT, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_G, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_L, 1'b0, 1'b0, KIND_TEXT);
        add_row(CH_O, 1'b1, 1'b0, KIND_TEXT);
        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
        end

        // random files
        while (rand_sent < RANDOM_ITEMS)
        begin
            file_bytes.delete();
            calm = ($urandom_range(0, 3) == 0);
            file_no++;
            if ((file_no % 40) == 3)
            begin
                // long file: clean up to eight bytes below the byte limit, arbitrary bytes after that
                len = $urandom_range(MAX_BYTES - 4, MAX_BYTES + 24);
                while (file_bytes.size() < MAX_BYTES - 8)
                begin
                    add_piece(1'b0);
                end
                while (file_bytes.size() < len)
                begin
                    file_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        repeat ($urandom_range(1, 30))
                            file_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    1, 2:
                    begin
                        // mail-like lines, mostly of the period length and mostly ending in space or bang
                        lines = $urandom_range(1, 3);
                        repeat (lines)
                        begin
                            brk = ($urandom_range(0, 3) == 0);
                            len = brk ? $urandom_range(19, 23) : LINE_PERIOD - 2;
                            repeat (len)
                                file_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE
                                                                                 : letter());
                            if (brk && ($urandom_range(0, 1) == 0))
                                file_bytes.push_back(letter());
                            else
                                file_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_BANG);
                            file_bytes.push_back(CH_NL);
                        end
                        repeat ($urandom_range(0, 3))
                            file_bytes.push_back(letter());
                    end
                    default:
                    begin
                        allow_bin = ($urandom_range(0, 3) == 0);
                        repeat ($urandom_range(1, 30))
                            add_piece(allow_bin);
                    end
                endcase
            end
            foreach (file_bytes[i])
            begin
                send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, KIND_TEXT);
            end
            rand_sent += file_bytes.size();
        end

        @(negedge clk);
        byte_ch.valid     <= 1'b0;
        byte_ch.final_req <= 1'b0;
        wait (pending_kinds.size() == 0);
        repeat (10) @(posedge clk);
        if ((errors == 0) && (pending_kinds.size() == 0))
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
